/* src/rwgd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwgd_pkg
// Shared types, register map and constants of the radar wave gesture detector.
// ----------------------------------------------------------------------------
package rwgd_pkg;

	localparam int unsigned IDLE_CLEAR_MS_DEF = 2000;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [15:0] EVENTS_NEEDED_RST = 16'd8;
	localparam logic [31:0] HOLD_TIME_RST     = 32'd3000;
	localparam logic [14:0] SPEED_MIN_RST     = 15'd8;

	localparam logic [1:0] REG_EVENTS_NEEDED = 2'd0;
	localparam logic [1:0] REG_HOLD_TIME     = 2'd1;
	localparam logic [1:0] REG_SPEED_MIN     = 2'd2;

	typedef struct packed {
		logic               frame_valid;
		logic signed [15:0] pos_x;
		logic signed [15:0] speed;
		logic        [31:0] time_ms;
	} frame_t;

	typedef struct packed {
		logic        detected;
		logic [15:0] detected_count;
		logic        ended;
		logic        wave_active;
	} result_t;

	typedef struct packed {
		logic [15:0] events_needed;
		logic [31:0] hold_time_ms;
		logic [14:0] speed_min;
	} cfg_t;

endpackage
`default_nettype wire

/* src/rwgd_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwgd_regs
// APB-style configuration registers: events needed, hold time, minimum speed.
// ----------------------------------------------------------------------------
module rwgd_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rwgd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rwgd_pkg::DATA_W-1:0] pwdata,
	output logic      [rwgd_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output rwgd_pkg::cfg_t                   cfg
);

	rwgd_pkg::cfg_t cfg_q;
	logic [1:0]     idx;
	logic           wr;

	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.events_needed <= rwgd_pkg::EVENTS_NEEDED_RST;
			cfg_q.hold_time_ms  <= rwgd_pkg::HOLD_TIME_RST;
			cfg_q.speed_min     <= rwgd_pkg::SPEED_MIN_RST;
		end else if (wr) begin
			case (idx)
				rwgd_pkg::REG_EVENTS_NEEDED: cfg_q.events_needed <= pwdata[15:0];
				rwgd_pkg::REG_HOLD_TIME:     cfg_q.hold_time_ms  <= pwdata[31:0];
				rwgd_pkg::REG_SPEED_MIN:     cfg_q.speed_min     <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rwgd_pkg::REG_EVENTS_NEEDED: prdata = {16'd0, cfg_q.events_needed};
			rwgd_pkg::REG_HOLD_TIME:     prdata = cfg_q.hold_time_ms;
			rwgd_pkg::REG_SPEED_MIN:     prdata = {17'd0, cfg_q.speed_min};
			default:                     prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* src/rwgd_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwgd_core
// Input register, event and timing logic with tracking state, result register.
// ----------------------------------------------------------------------------
module rwgd_core #(
	parameter int unsigned IDLE_CLEAR_MS = rwgd_pkg::IDLE_CLEAR_MS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  rwgd_pkg::cfg_t         cfg,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  rwgd_pkg::frame_t       req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rwgd_pkg::result_t      rsp
);

	localparam logic [31:0] IDLE_CLR = 32'(IDLE_CLEAR_MS);

	logic              valid_s1;
	rwgd_pkg::frame_t  frame_s1;
	logic              valid_s2;
	rwgd_pkg::result_t result_s2;

	logic        first_pending_q;
	logic [15:0] prev_speed_q;
	logic [15:0] prev_x_q;
	logic [15:0] event_total_q;
	logic [31:0] last_event_time_q;
	logic        is_active_q;

	logic        advance;
	logic [15:0] mag_prev;
	logic [15:0] mag_cur;
	logic        prev_sp_pos, prev_sp_neg, cur_sp_pos, cur_sp_neg;
	logic        prev_x_pos, prev_x_neg, cur_x_pos, cur_x_neg;
	logic        speed_evt, x_evt, evt;
	logic [15:0] cnt_inc;
	logic        det;
	logic        active_det;
	logic [31:0] elapsed;
	logic        end_hit;
	logic        active_nx;
	logic [15:0] cnt_nx;
	rwgd_pkg::result_t result_nx;

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = valid_s2;
	assign rsp       = result_s2;

	always_comb begin
		mag_prev = prev_speed_q[15] ? 16'(-prev_speed_q) : prev_speed_q;
		mag_cur  = frame_s1.speed[15] ? 16'(-frame_s1.speed) : frame_s1.speed;

		prev_sp_neg = prev_speed_q[15];
		prev_sp_pos = !prev_speed_q[15] && (prev_speed_q != 16'd0);
		cur_sp_neg  = frame_s1.speed[15];
		cur_sp_pos  = !frame_s1.speed[15] && (frame_s1.speed != 16'sd0);
		prev_x_neg  = prev_x_q[15];
		prev_x_pos  = !prev_x_q[15] && (prev_x_q != 16'd0);
		cur_x_neg   = frame_s1.pos_x[15];
		cur_x_pos   = !frame_s1.pos_x[15] && (frame_s1.pos_x != 16'sd0);

		speed_evt = (mag_prev >= {1'b0, cfg.speed_min}) && (mag_cur >= {1'b0, cfg.speed_min})
			&& ((prev_sp_pos && cur_sp_neg) || (prev_sp_neg && cur_sp_pos));
		x_evt = (prev_x_pos && cur_x_neg) || (prev_x_neg && cur_x_pos);
		evt   = !first_pending_q && (speed_evt || x_evt);

		cnt_inc = event_total_q;
		if (evt && (event_total_q != 16'hFFFF)) begin
			cnt_inc = event_total_q + 16'd1;
		end

		det        = evt && !is_active_q && (cnt_inc >= cfg.events_needed);
		active_det = is_active_q || det;
		elapsed    = evt ? 32'd0 : (frame_s1.time_ms - last_event_time_q);
		end_hit    = active_det && (elapsed >= cfg.hold_time_ms);
		active_nx  = active_det && !end_hit;

		cnt_nx = end_hit ? 16'd0 : cnt_inc;
		if (!active_nx && (elapsed >= IDLE_CLR)) begin
			cnt_nx = 16'd0;
		end

		if (frame_s1.frame_valid) begin
			result_nx.detected       = det;
			result_nx.detected_count = det ? cnt_inc : 16'd0;
			result_nx.ended          = end_hit;
			result_nx.wave_active    = active_nx;
		end else begin
			result_nx.detected       = 1'b0;
			result_nx.detected_count = 16'd0;
			result_nx.ended          = 1'b0;
			result_nx.wave_active    = is_active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			frame_s1 <= req;
		end
		if (advance) begin
			result_s2 <= result_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pending_q   <= 1'b1;
			prev_speed_q      <= 16'd0;
			prev_x_q          <= 16'd0;
			event_total_q     <= 16'd0;
			last_event_time_q <= 32'd0;
			is_active_q       <= 1'b0;
		end else if (advance) begin
			if (!frame_s1.frame_valid) begin
				first_pending_q <= 1'b1;
			end else begin
				first_pending_q <= 1'b0;
				prev_speed_q    <= frame_s1.speed;
				prev_x_q        <= frame_s1.pos_x;
				event_total_q   <= cnt_nx;
				is_active_q     <= active_nx;
				if (evt) begin
					last_event_time_q <= frame_s1.time_ms;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* src/radar_wave_gesture_detector.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// radar_wave_gesture_detector
// Counts direction events in radar target frames and flags wave gestures.
//
// Frames enter on the req channel (req_valid/req_ready, payload req) and one
// result per frame leaves on the rsp channel (rsp_valid/rsp_ready, payload
// rsp), in order. A frame is held in the input register, where the
// event, count and timing logic runs against the tracking state; the result
// is written to the output register when that register is free or being
// drained, and shows on rsp from there. One frame is taken every cycle
// while rsp is drained. When rsp_ready is low the result holds and the input
// register fills; then req_ready drops until the result is taken. Reset
// clears the tracking state (first frame pending, count zero, not active),
// empties both registers and loads the register defaults: events needed 8,
// hold time 3000 ms, minimum speed 8. Registers are at byte addresses 0, 4
// and 8 of the APB port; the user must write them only while the block is
// idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module radar_wave_gesture_detector #(
	parameter int unsigned IDLE_CLEAR_MS = rwgd_pkg::IDLE_CLEAR_MS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rwgd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rwgd_pkg::DATA_W-1:0] pwdata,
	output logic      [rwgd_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  rwgd_pkg::frame_t                 req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output rwgd_pkg::result_t                rsp
);

	rwgd_pkg::cfg_t cfg;

	rwgd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rwgd_core #(
		.IDLE_CLEAR_MS (IDLE_CLEAR_MS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

/* src/rwgd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwgd_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rwgd_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input rwgd_pkg::result_t      rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result transfer changed");

	a_det_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.detected |-> rsp.detected_count == 16'd0)
		else $error("count without detection");

	a_det_active: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.detected |-> rsp.wave_active || rsp.ended)
		else $error("detection left wave inactive");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ended |-> !rsp.wave_active)
		else $error("ended wave still active");

endmodule

bind radar_wave_gesture_detector rwgd_checker u_rwgd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire
